>>> sv/abo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abo_pkg
// Shared widths, constants, register codes and the CORDIC angle table for the
// arctangent block with branch offset.
// ----------------------------------------------------------------------------
package abo_pkg;

   // defaults for the top-level parameters
   localparam int FRAC_BITS_DEF    = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   // word widths
   localparam int VALUE_WIDTH  = 32;
   localparam int ANGLE_WIDTH  = 35;
   localparam int BRANCH_WIDTH = 11;
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;

   // internal fixed-point formats
   localparam int GUARD_BITS = 8;
   localparam int ANG_FRAC   = 30;
   localparam int DEG_FRAC   = 24;
   localparam int Z_WIDTH    = 33;
   localparam int X_WIDTH    = VALUE_WIDTH + GUARD_BITS + 3;
   localparam int ACC_WIDTH  = 48;
   localparam int PROD_WIDTH = 65;

   localparam logic signed [32:0] PI_Q30          = 33'sd3373259426;
   localparam logic signed [31:0] DEG_PER_RAD_Q24 = 32'sd961263669;
   localparam logic signed [8:0]  HALF_TURN_DEG   = 9'sd180;

   // register codes, taken from paddr bit 2
   typedef enum logic [0:0] {
      REG_DEGREE_MODE  = 1'b0,
      REG_BRANCH_INDEX = 1'b1
   } reg_index_type;

   // round(atan(2^-i) * 2^30)
   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'd843314857;
         5'd1:  r = 32'd497837829;
         5'd2:  r = 32'd263043837;
         5'd3:  r = 32'd133525159;
         5'd4:  r = 32'd67021687;
         5'd5:  r = 32'd33543516;
         5'd6:  r = 32'd16775851;
         5'd7:  r = 32'd8388437;
         5'd8:  r = 32'd4194283;
         5'd9:  r = 32'd2097149;
         5'd10: r = 32'd1048576;
         5'd11: r = 32'd524288;
         5'd12: r = 32'd262144;
         5'd13: r = 32'd131072;
         5'd14: r = 32'd65536;
         5'd15: r = 32'd32768;
         5'd16: r = 32'd16384;
         5'd17: r = 32'd8192;
         5'd18: r = 32'd4096;
         5'd19: r = 32'd2048;
         5'd20: r = 32'd1024;
         5'd21: r = 32'd512;
         5'd22: r = 32'd256;
         5'd23: r = 32'd128;
         5'd24: r = 32'd64;
         5'd25: r = 32'd32;
         5'd26: r = 32'd16;
         5'd27: r = 32'd8;
         5'd28: r = 32'd4;
         5'd29: r = 32'd2;
         5'd30: r = 32'd1;
         5'd31: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

>>> sv/abo_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abo_req_if
// Input channel: one tangent word per handshake.
// ----------------------------------------------------------------------------
interface abo_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [abo_pkg::VALUE_WIDTH-1:0]    value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

>>> sv/abo_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abo_rsp_if
// Result channel: one angle word per handshake.
// ----------------------------------------------------------------------------
interface abo_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [abo_pkg::ANGLE_WIDTH-1:0]    angle;

   modport source (output valid, output angle, input ready);
   modport sink   (input valid, input angle, output ready);
endinterface
`default_nettype wire

>>> sv/arctangent_with_branch_offset.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word per cycle while rsp.ready is high; set by the unrolled
// CORDIC, one micro-rotation per register stage, and a three-stage scaling tail.
// Each stage holds its word until the next one frees, so stalls drop nothing.
// Reset clears all stage valid bits, degree_mode and branch_index.
// ----------------------------------------------------------------------------
// arctangent_with_branch_offset
// Pipelined CORDIC arctangent (vectoring) plus branch_index half turns, in
// radians or degrees, with an APB-style register port.
// ----------------------------------------------------------------------------
module arctangent_with_branch_offset #(
   parameter int FRAC_BITS    = abo_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = abo_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   abo_req_if.sink                            req,
   abo_rsp_if.source                          rsp,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [abo_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [abo_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic      [abo_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int XW = abo_pkg::X_WIDTH;
   localparam int ZW = abo_pkg::Z_WIDTH;
   localparam int AW = abo_pkg::ACC_WIDTH;
   localparam int PW = abo_pkg::PROD_WIDTH;
   localparam int BW = abo_pkg::BRANCH_WIDTH;
   localparam int OW = abo_pkg::ANGLE_WIDTH;

   // stage map: 0 input, 1..S micro-rotations, then product, round, output
   localparam int S     = CORDIC_STEPS;
   localparam int ST_A  = S + 1;
   localparam int ST_B  = S + 2;
   localparam int ST_C  = S + 3;
   localparam int NS    = S + 4;

   localparam int RAD_SHIFT = abo_pkg::ANG_FRAC - FRAC_BITS;
   localparam int DEG_SHIFT = abo_pkg::ANG_FRAC + abo_pkg::DEG_FRAC - FRAC_BITS;

   localparam logic signed [XW-1:0] X_INIT   = XW'(1) <<< (FRAC_BITS + abo_pkg::GUARD_BITS);
   localparam logic signed [AW-1:0] RAD_HALF = AW'(1) <<< (RAD_SHIFT - 1);
   localparam logic signed [PW-1:0] DEG_HALF = PW'(1) <<< (DEG_SHIFT - 1);
   localparam logic signed [AW-1:0] SAT_MAX  = (AW'(1) <<< (OW - 1)) - AW'(1);
   localparam logic signed [AW-1:0] SAT_MIN  = -(AW'(1) <<< (OW - 1));

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic                 degree_mode_ff;
   logic signed [BW-1:0] branch_index_ff;
   abo_pkg::reg_index_type csr_sel;
   logic                 csr_wr;

   assign csr_sel    = abo_pkg::reg_index_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_mode_ff  <= 1'b0;
         branch_index_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_sel)
            abo_pkg::REG_DEGREE_MODE:  degree_mode_ff  <= csr_pwdata[0];
            abo_pkg::REG_BRANCH_INDEX: branch_index_ff <= signed'(csr_pwdata[BW-1:0]);
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         abo_pkg::REG_DEGREE_MODE:  csr_prdata = {{(abo_pkg::CSR_DW-1){1'b0}}, degree_mode_ff};
         abo_pkg::REG_BRANCH_INDEX: csr_prdata = abo_pkg::CSR_DW'(branch_index_ff);
      endcase
   end

   // ---------------------------------------------------------------------
   // stage handshake: a stage loads when empty or when its word moves on
   // ---------------------------------------------------------------------
   logic [NS-1:0] vld_ff;
   logic [NS:0]   rdy;

   assign rdy[NS]   = rsp.ready;
   assign req.ready = rdy[0];

   for (genvar k = 0; k < NS; k++) begin : g_hs
      logic vld_in;

      if (k == 0) begin : g_first
         assign vld_in = req.valid;
      end else begin : g_next
         assign vld_in = vld_ff[k-1];
      end

      assign rdy[k] = !vld_ff[k] || rdy[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            vld_ff[k] <= vld_in;
         end
      end
   end

   // ---------------------------------------------------------------------
   // input stage: vector (1, value) with guard bits
   // ---------------------------------------------------------------------
   logic signed [XW-1:0] x_ff [0:S];
   logic signed [XW-1:0] y_ff [0:S];
   logic signed [ZW-1:0] z_ff [0:S];

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         x_ff[0] <= X_INIT;
         y_ff[0] <= XW'(req.value) <<< abo_pkg::GUARD_BITS;
         z_ff[0] <= '0;
      end
   end

   // ---------------------------------------------------------------------
   // micro-rotations, one per stage; rotate towards y = 0
   // ---------------------------------------------------------------------
   for (genvar k = 1; k <= S; k++) begin : g_rot
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      logic signed [ZW-1:0] da;
      logic                 up;

      assign dx = y_ff[k-1] >>> (k - 1);
      assign dy = x_ff[k-1] >>> (k - 1);
      assign da = signed'({1'b0, abo_pkg::atan_q30(5'(k - 1))});
      assign up = !y_ff[k-1][XW-1];

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            x_ff[k] <= up ? x_ff[k-1] + dx : x_ff[k-1] - dx;
            y_ff[k] <= up ? y_ff[k-1] - dy : y_ff[k-1] + dy;
            z_ff[k] <= up ? z_ff[k-1] + da : z_ff[k-1] - da;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stage A: products (half turns in Q30 rad, degree scaling, turn in deg)
   // ---------------------------------------------------------------------
   logic signed [AW-1:0] rad_turn_ff;
   logic signed [PW-1:0] deg_prod_ff;
   logic signed [AW-1:0] deg_turn_ff;
   logic signed [ZW-1:0] z_a_ff;

   always_ff @(posedge clock) begin
      if (rdy[ST_A]) begin
         rad_turn_ff <= AW'(branch_index_ff) * AW'(abo_pkg::PI_Q30);
         deg_prod_ff <= PW'(z_ff[S]) * PW'(abo_pkg::DEG_PER_RAD_Q24);
         deg_turn_ff <= (AW'(branch_index_ff) * AW'(abo_pkg::HALF_TURN_DEG)) <<< FRAC_BITS;
         z_a_ff      <= z_ff[S];
      end
   end

   // ---------------------------------------------------------------------
   // stage B: round half up to FRAC_BITS, pick the unit
   // ---------------------------------------------------------------------
   logic signed [AW-1:0] rad_q;
   logic signed [PW-1:0] deg_q;
   logic signed [AW-1:0] pick_ff;
   logic signed [AW-1:0] turn_b_ff;

   assign rad_q = (rad_turn_ff + AW'(z_a_ff) + RAD_HALF) >>> RAD_SHIFT;
   assign deg_q = (deg_prod_ff + DEG_HALF) >>> DEG_SHIFT;

   always_ff @(posedge clock) begin
      if (rdy[ST_B]) begin
         pick_ff   <= degree_mode_ff ? deg_q[AW-1:0] : rad_q;
         turn_b_ff <= degree_mode_ff ? deg_turn_ff : '0;
      end
   end

   // ---------------------------------------------------------------------
   // stage C: in degree mode add whole degrees, saturate to the angle width
   // ---------------------------------------------------------------------
   logic signed [AW-1:0] sum_c;
   logic signed [OW-1:0] angle_in;
   logic signed [OW-1:0] angle_ff;

   assign sum_c = pick_ff + turn_b_ff;

   always_comb begin
      priority if (sum_c > SAT_MAX) begin
         angle_in = SAT_MAX[OW-1:0];
      end else if (sum_c < SAT_MIN) begin
         angle_in = SAT_MIN[OW-1:0];
      end else begin
         angle_in = sum_c[OW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_C]) begin
         angle_ff <= angle_in;
      end
   end

   assign rsp.valid = vld_ff[NS-1];
   assign rsp.angle = angle_ff;

endmodule
`default_nettype wire
